>>> hdl/egress_address_allowlist_filter_assert.svh
// Assertion macros for the egress allowlist filter.
// Used by the top level; relies on a clock named clk and reset named rst.
`ifndef EGRESS_ADDRESS_ALLOWLIST_FILTER_ASSERT_SVH
`define EGRESS_ADDRESS_ALLOWLIST_FILTER_ASSERT_SVH
// Same-cycle implication.
`define EAAF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define EAAF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hdl/eaaf_pkg.sv
// Package for the egress allowlist filter: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package eaaf_pkg;
  localparam int TableEntriesDefault = 4096;

  localparam logic OP_BYTE   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [5:0]  FULL_POSITION = 6'd42;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP = 8'd17;
  localparam logic [15:0] PORT_DNS = 16'd53;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic start_scan;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_busy;
    logic out_free;
  } dp_sts_t;
endpackage
`default_nettype wire

>>> hdl/eaaf_ctrl.sv
// Controller for the egress allowlist filter: accept, scan, respond.
// Depends on eaaf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module eaaf_ctrl
  import eaaf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire logic    operation,
  input  wire logic    frame_end,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);
  ctrl_state_t state, state_next;
  logic accept, needs_result;

  assign accept = in_valid && (state == S_IDLE);
  assign needs_result = (operation == OP_INSERT) || frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && needs_result) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (!sts.scan_busy) state_next = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != S_IDLE);
    cmd.capture = accept;
    cmd.start_scan = accept && needs_result;
    cmd.load_out = (state == S_RESP) && sts.out_free;
  end
endmodule
`default_nettype wire

>>> hdl/eaaf_datapath.sv
// Datapath for the egress allowlist filter: header capture, allowlist memory
// with linear scan, and the output register. Depends on eaaf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module eaaf_datapath
  import eaaf_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  output dp_sts_t          sts,
  input  wire logic        operation,
  input  wire logic [7:0]  data_byte,
  input  wire logic        frame_end,
  input  wire logic [31:0] allow_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             result_kind,
  output logic             drop,
  output logic [1:0]       insert_status
);
  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] LAST_COUNT = CW'(TABLE_ENTRIES);

  logic [31:0] mem [TABLE_ENTRIES];

  logic [5:0]  byte_position, pos_next;
  logic [15:0] ether_type, ether_next;
  logic [7:0]  ip_protocol, proto_next;
  logic [31:0] destination_address, dest_next;
  logic [15:0] udp_destination_port, port_next;

  logic [31:0]   key;
  logic          kind;
  logic          fixed_pass, fixed_pass_next;
  logic [CW-1:0] count, idx;
  logic          scanning, pend, hit;
  logic [31:0]   rd_data;
  logic          full;
  logic [7:0]    first, second;

  // Header capture from the current byte.
  always_comb begin
    ether_next = ether_type;
    proto_next = ip_protocol;
    dest_next = destination_address;
    port_next = udp_destination_port;
    unique case (byte_position)
      6'd12: ether_next = {data_byte, ether_type[7:0]};
      6'd13: ether_next = {ether_type[15:8], data_byte};
      6'd23: proto_next = data_byte;
      6'd30, 6'd31, 6'd32, 6'd33: dest_next = {destination_address[23:0], data_byte};
      6'd36: port_next = {data_byte, udp_destination_port[7:0]};
      6'd37: port_next = {udp_destination_port[15:8], data_byte};
      default: ;
    endcase
    pos_next = (byte_position < FULL_POSITION) ? byte_position + 6'd1 : byte_position;
    first = dest_next[31:24];
    second = dest_next[23:16];
    fixed_pass_next =
      (pos_next < 6'd14) || (ether_next != ETHERTYPE_IPV4) || (pos_next < 6'd34) ||
      (first == 8'd127) ||
      ((proto_next == PROTO_UDP) && ((pos_next < 6'd42) || (port_next == PORT_DNS))) ||
      (first == 8'd142 && second == 8'd250) || (first == 8'd172 && second == 8'd217) ||
      (first == 8'd216 && second == 8'd58)  || (first == 8'd8 && second == 8'd8) ||
      (first == 8'd104 && second == 8'd21)  || (first == 8'd104 && second == 8'd18) ||
      (first == 8'd172 && second == 8'd67);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      ether_type <= '0;
      ip_protocol <= '0;
      destination_address <= '0;
      udp_destination_port <= '0;
    end else if (cmd.capture) begin
      if (operation == OP_BYTE) begin
        if (frame_end) begin
          byte_position <= '0;
          ether_type <= '0;
          ip_protocol <= '0;
          destination_address <= '0;
          udp_destination_port <= '0;
        end else begin
          byte_position <= pos_next;
          ether_type <= ether_next;
          ip_protocol <= proto_next;
          destination_address <= dest_next;
          udp_destination_port <= port_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      if (operation == OP_INSERT) begin
        key <= allow_address;
        kind <= KIND_ACK;
      end else begin
        key <= dest_next;
        kind <= KIND_VERDICT;
      end
      fixed_pass <= fixed_pass_next;
    end
  end

  assign full = (count == LAST_COUNT);

  // Linear scan over the filled entries, one read per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
      pend <= 1'b0;
      idx <= '0;
      hit <= 1'b0;
    end else if (cmd.start_scan) begin
      scanning <= 1'b1;
      pend <= 1'b0;
      idx <= '0;
      hit <= 1'b0;
    end else if (scanning) begin
      if (pend && (rd_data == key)) hit <= 1'b1;
      if (idx != count) begin
        pend <= 1'b1;
        idx <= idx + CW'(1);
      end else begin
        pend <= 1'b0;
        if (!pend) scanning <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scanning && (idx != count)) rd_data <= mem[idx[AW-1:0]];
    if (cmd.load_out && (kind == KIND_ACK) && !hit && !full) mem[count[AW-1:0]] <= key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load_out && (kind == KIND_ACK) && !hit && !full) begin
      count <= count + CW'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result_kind <= kind;
      if (kind == KIND_ACK) begin
        drop <= 1'b0;
        insert_status <= hit ? ST_PRESENT : (full ? ST_FULL : ST_ADDED);
      end else begin
        drop <= !(fixed_pass || hit);
        insert_status <= ST_ADDED;
      end
    end
  end

  assign sts.scan_busy = scanning;
  assign sts.out_free = !out_valid || !out_stall;
endmodule
`default_nettype wire

>>> hdl/egress_address_allowlist_filter.sv
// Top level of the egress allowlist filter: controller plus datapath.
// Depends on eaaf_pkg, eaaf_ctrl, eaaf_datapath and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
// Frame bytes and allowlist inserts share one input channel. A frame byte
// that is not the last one does not stall the input. The last byte of a
// frame and an insert each scan the allowlist memory linearly, one entry
// per cycle through its single read port. Such an item holds the input
// until its scan is done and its result enters the output register,
// which waits while the output stall holds a waiting result. Results
// leave through an output register; the verdict is 0 for pass and 1 for
// drop, an insert reports added, already present or full. Reset empties the
// table at once by clearing its fill count, so no clearing pass runs.
module egress_address_allowlist_filter
  import eaaf_pkg::*;
#(
  parameter int TABLE_ENTRIES = TableEntriesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        operation,
  input  wire logic [7:0]  data_byte,
  input  wire logic        frame_end,
  input  wire logic [31:0] allow_address,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             result_kind,
  output logic             drop,
  output logic [1:0]       insert_status
);
  `include "egress_address_allowlist_filter_assert.svh"

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequence each transfer: capture, then scan and respond for a last byte or an insert.
  eaaf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .frame_end (frame_end),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold header fields, the table and the result register.
  eaaf_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .operation     (operation),
    .data_byte     (data_byte),
    .frame_end     (frame_end),
    .allow_address (allow_address),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .drop          (drop),
    .insert_status (insert_status)
  );

  // An acknowledgement never carries a drop; a verdict carries only the added status.
  `EAAF_ASSERT_NOW(a_ack_no_drop, out_valid && (result_kind == KIND_ACK), !drop)
  `EAAF_ASSERT_NOW(a_verdict_no_status, out_valid && !result_kind, insert_status == ST_ADDED)
  // A result-producing transfer blocks the input while it is scanned.
  `EAAF_ASSERT_NEXT(a_busy_after_result_item, in_valid && !in_stall && (operation || frame_end), in_stall)
endmodule
`default_nettype wire
